>>> rtl/length_prefixed_message_deframer_unit_defines.svh
// ----------------------------------------------------------------------------
// Length-prefixed message deframer: assertion macros
// Shared property shorthands for the checker files.
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_MESSAGE_DEFRAMER_UNIT_DEFINES_SVH
`define LENGTH_PREFIXED_MESSAGE_DEFRAMER_UNIT_DEFINES_SVH

// Same-cycle implication under reset.
`define LPMD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication under reset.
`define LPMD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/lpmd_pkg.sv
// ----------------------------------------------------------------------------
// lpmd_pkg
// Types and constants shared by the deframer modules.
// ----------------------------------------------------------------------------
package lpmd_pkg;

  // Bytes per header word (channel and length); range 1..8.
  localparam int HEADER_WORD_BYTES = 4;
  localparam int HDR_IDX_W = (HEADER_WORD_BYTES > 1) ? $clog2(HEADER_WORD_BYTES) : 1;

  localparam int WORD_W = 32;
  localparam logic [WORD_W-1:0] MAX_LENGTH_RST = 32'd65536;

  // Result queue between parser and output stage.
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH     = 2'd1;

  typedef enum logic [1:0] {
    PH_CHANNEL = 2'd0,
    PH_LENGTH  = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_HALTED  = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [7:0]        data;
    logic [WORD_W-1:0] channel;
    logic              last;
  } result_t;

endpackage

>>> rtl/lpmd_front.sv
// ----------------------------------------------------------------------------
// lpmd_front
// Byte parser: header assembly, length check, payload count, config regs.
// ----------------------------------------------------------------------------
module lpmd_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [7:0]                        in_byte_i,
  input  logic                              cfg_valid_i,
  input  logic [lpmd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [lpmd_pkg::WORD_W-1:0]       cfg_data_i,
  input  logic                              fifo_full_i,
  output logic                              push_o,
  output lpmd_pkg::result_t                 push_data_o
);

  lpmd_pkg::phase_e                    phase_q, phase_d;
  logic [lpmd_pkg::HDR_IDX_W-1:0]      hdr_idx_q, hdr_idx_d;
  logic [lpmd_pkg::WORD_W-1:0]         assembly_q, assembly_d;
  logic [lpmd_pkg::WORD_W-1:0]         channel_id_q, channel_id_d;
  logic [lpmd_pkg::WORD_W-1:0]         remaining_q, remaining_d;
  logic                                chan_en_q, chan_en_d;
  logic [lpmd_pkg::WORD_W-1:0]         max_len_q, max_len_d;

  logic                                accept;
  logic                                hdr_done;
  logic [lpmd_pkg::WORD_W-1:0]         hdr_word;
  lpmd_pkg::phase_e                    start_phase;

  assign in_ready_o  = !fifo_full_i;
  assign accept      = in_valid_i && in_ready_o;
  assign hdr_word    = {assembly_q[lpmd_pkg::WORD_W-9:0], in_byte_i};
  assign hdr_done    = (hdr_idx_q == lpmd_pkg::HDR_IDX_W'(lpmd_pkg::HEADER_WORD_BYTES - 1));
  assign start_phase = chan_en_q ? lpmd_pkg::PH_CHANNEL : lpmd_pkg::PH_LENGTH;

  always_comb begin
    phase_d      = phase_q;
    hdr_idx_d    = hdr_idx_q;
    assembly_d   = assembly_q;
    channel_id_d = channel_id_q;
    remaining_d  = remaining_q;
    chan_en_d    = chan_en_q;
    max_len_d    = max_len_q;
    push_o       = 1'b0;
    push_data_o.kind    = lpmd_pkg::KIND_BYTE;
    push_data_o.data    = '0;
    push_data_o.channel = chan_en_q ? channel_id_q : '0;
    push_data_o.last    = 1'b0;

    if (accept) begin
      case (phase_q)
        lpmd_pkg::PH_CHANNEL, lpmd_pkg::PH_LENGTH: begin
          assembly_d = hdr_word;
          hdr_idx_d  = hdr_idx_q + 1'b1;
          if (hdr_done) begin
            hdr_idx_d  = '0;
            assembly_d = '0;
            if (phase_q == lpmd_pkg::PH_CHANNEL) begin
              channel_id_d = hdr_word;
              phase_d      = lpmd_pkg::PH_LENGTH;
            end else begin
              remaining_d = hdr_word;
              if (hdr_word > max_len_q) begin
                phase_d          = lpmd_pkg::PH_HALTED;
                push_o           = 1'b1;
                push_data_o.kind = lpmd_pkg::KIND_ERROR;
                push_data_o.last = 1'b1;
              end else if (hdr_word == '0) begin
                phase_d          = start_phase;
                push_o           = 1'b1;
                push_data_o.kind = lpmd_pkg::KIND_EMPTY;
                push_data_o.last = 1'b1;
              end else begin
                phase_d = lpmd_pkg::PH_PAYLOAD;
              end
            end
          end
        end
        lpmd_pkg::PH_PAYLOAD: begin
          remaining_d      = remaining_q - 1'b1;
          push_o           = 1'b1;
          push_data_o.data = in_byte_i;
          if (remaining_q == lpmd_pkg::WORD_W'(1)) begin
            push_data_o.last = 1'b1;
            phase_d          = start_phase;
            hdr_idx_d        = '0;
            assembly_d       = '0;
          end
        end
        default: begin
          // halted: byte dropped
        end
      endcase
    end

    if (cfg_valid_i) begin
      case (cfg_index_i)
        lpmd_pkg::CFG_CHANNEL_ENABLE: begin
          if (cfg_data_i[0] != chan_en_q) begin
            chan_en_d = cfg_data_i[0];
            // mode change drops any partial frame
            if (phase_q != lpmd_pkg::PH_HALTED) begin
              remaining_d = '0;
              hdr_idx_d   = '0;
              assembly_d  = '0;
              phase_d     = cfg_data_i[0] ? lpmd_pkg::PH_CHANNEL : lpmd_pkg::PH_LENGTH;
            end
          end
        end
        lpmd_pkg::CFG_MAX_LENGTH: begin
          max_len_d = cfg_data_i;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= lpmd_pkg::PH_LENGTH;
      hdr_idx_q    <= '0;
      assembly_q   <= '0;
      channel_id_q <= '0;
      remaining_q  <= '0;
      chan_en_q    <= 1'b0;
      max_len_q    <= lpmd_pkg::MAX_LENGTH_RST;
    end else begin
      phase_q      <= phase_d;
      hdr_idx_q    <= hdr_idx_d;
      assembly_q   <= assembly_d;
      channel_id_q <= channel_id_d;
      remaining_q  <= remaining_d;
      chan_en_q    <= chan_en_d;
      max_len_q    <= max_len_d;
    end
  end

endmodule

>>> rtl/lpmd_fifo.sv
// ----------------------------------------------------------------------------
// lpmd_fifo
// Short result queue between parser and output stage.
// ----------------------------------------------------------------------------
module lpmd_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  lpmd_pkg::result_t  push_data_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output lpmd_pkg::result_t  pop_data_o
);

  lpmd_pkg::result_t                mem_q [lpmd_pkg::FIFO_DEPTH];
  logic [lpmd_pkg::FIFO_PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [lpmd_pkg::FIFO_PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [lpmd_pkg::FIFO_CNT_W-1:0]  count_q, count_d;

  localparam logic [lpmd_pkg::FIFO_PTR_W-1:0] PtrLast =
    lpmd_pkg::FIFO_PTR_W'(lpmd_pkg::FIFO_DEPTH - 1);

  assign full_o     = (count_q == lpmd_pkg::FIFO_CNT_W'(lpmd_pkg::FIFO_DEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> rtl/lpmd_back.sv
// ----------------------------------------------------------------------------
// lpmd_back
// Output register: drains the result queue onto the output channel.
// ----------------------------------------------------------------------------
module lpmd_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  lpmd_pkg::result_t  head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output lpmd_pkg::result_t  out_res_o
);

  logic               out_valid_q, out_valid_d;
  lpmd_pkg::result_t  out_res_q;

  // load when the register is free or its transaction completes now
  assign pop_o = !empty_i && (!out_valid_q || out_ready_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_res_q <= head_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

endmodule

>>> rtl/length_prefixed_message_deframer_unit.sv
// ----------------------------------------------------------------------------
// length_prefixed_message_deframer_unit
// Splits a byte stream into length-prefixed messages, optional channel word.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake              Payload
//  in       sink       in_valid_i/in_ready_o    in_byte_i
//  out      source     out_valid_o/out_ready_i  kind_o, data_o, channel_o, last_o
//  cfg      sink       cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//
//  One byte per clock while the queue is not full; the parser handles each
//  byte with one header shift, one 32-bit compare or decrement.
//  Each result is written into the queue, then loaded into the output
//  register, and out_valid_o rises when that register is loaded.
//  The two-entry queue plus output register let the input keep flowing while
//  a result waits; in_ready_o drops only when the queue is full.
//  Reset: length-header phase, channel mode off, max length 65536, no
//  results pending. cfg_ready_o is always high.
//  After an oversize length the error result is sent and all later bytes
//  are taken and dropped until reset.
//
module length_prefixed_message_deframer_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [7:0]                        in_byte_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        kind_o,
  output logic [7:0]                        data_o,
  output logic [lpmd_pkg::WORD_W-1:0]       channel_o,
  output logic                              last_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [lpmd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [lpmd_pkg::WORD_W-1:0]       cfg_data_i
);

  logic               fifo_full;
  logic               fifo_empty;
  logic               push;
  logic               pop;
  lpmd_pkg::result_t  push_data;
  lpmd_pkg::result_t  head;
  lpmd_pkg::result_t  out_res;

  // registers must be written only while idle (the block does not enforce it); no backpressure needed
  assign cfg_ready_o = 1'b1;

  // front: parses bytes, emits results into the queue
  lpmd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_byte_i   (in_byte_i),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .fifo_full_i (fifo_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // queue decouples parser stalls from output stalls
  lpmd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (fifo_full),
    .pop_i       (pop),
    .empty_o     (fifo_empty),
    .pop_data_o  (head)
  );

  // back: output register toward the consumer
  lpmd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (fifo_empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (out_res)
  );

  assign kind_o    = out_res.kind;
  assign data_o    = out_res.data;
  assign channel_o = out_res.channel;
  assign last_o    = out_res.last;

endmodule

>>> rtl/lpmd_checker.sv
// ----------------------------------------------------------------------------
// lpmd_checker
// Port-level properties of the deframer, bound onto the top level.
// ----------------------------------------------------------------------------
`include "length_prefixed_message_deframer_unit_defines.svh"

module lpmd_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         out_valid_o,
  input  logic                         out_ready_i,
  input  logic [1:0]                   kind_o,
  input  logic [7:0]                   data_o,
  input  logic                         last_o
);

  logic is_byte;
  logic is_error;

  assign is_byte  = (kind_o == lpmd_pkg::KIND_BYTE);
  assign is_error = (kind_o == lpmd_pkg::KIND_ERROR);

  `LPMD_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o, "output dropped while stalled")
  `LPMD_ASSERT_IMP(a_data_zero, clk_i, rst_ni, out_valid_o && !is_byte, data_o == 8'd0, "data nonzero on non-byte result")
  `LPMD_ASSERT_IMP(a_last_set, clk_i, rst_ni, out_valid_o && !is_byte, last_o, "empty or error result without last")
  `LPMD_ASSERT_NXT(a_halt_quiet, clk_i, rst_ni, out_valid_o && out_ready_i && is_error, !out_valid_o, "result after length error")

endmodule

bind length_prefixed_message_deframer_unit lpmd_checker u_lpmd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .kind_o      (kind_o),
  .data_o      (data_o),
  .last_o      (last_o)
);

>>> sim/tb_length_prefixed_message_deframer_unit.sv
// ----------------------------------------------------------------------------
// tb_length_prefixed_message_deframer_unit
// Self-checking bench for the deframer. A byte-level deframer predictor runs
// beside the block and checks every output transaction against it. Traffic
// is a short directed set of frames followed by random frame streams under
// several register settings. The run ends with an oversize length so that
// the halted state is covered last.
// ----------------------------------------------------------------------------
module tb_length_prefixed_message_deframer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import lpmd_pkg::*;

  // Indexes past the register list; the block must ignore writes to them.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  // out_valid_o rises only after the queue and output register. A byte that makes no result
  // may still be inside the block, so wait this long before a register write.
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_BYTES   = 200;

  // --------------------------------------------------------------------------
  // DUT ports. Every input starts at a known value.
  // --------------------------------------------------------------------------
  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  logic [7:0]        in_byte_i   = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [1:0]        kind_o;
  logic [7:0]        data_o;
  logic [WORD_W-1:0] channel_o;
  logic              last_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [WORD_W-1:0] cfg_data_i  = '0;

  length_prefixed_message_deframer_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_byte_i   (in_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .data_o      (data_o),
    .channel_o   (channel_o),
    .last_o      (last_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Shared bench state
  // --------------------------------------------------------------------------
  logic [7:0] tx_bytes[$];          // bytes waiting for the driver
  result_t    pending_results[$];   // predicted results, oldest first
  int         fail_cnt = 0;
  int         res_cnt  = 0;         // output transactions seen so far
  bit         frame_mode = 1'b0;    // channel mode the stimulus is framing for

  // --------------------------------------------------------------------------
  // Deframer predictor: own copy of registers and parse state.
  // --------------------------------------------------------------------------
  bit                m_chan_en;
  logic [WORD_W-1:0] m_max;
  phase_e            m_phase;
  int                m_hidx;
  logic [WORD_W-1:0] m_asm;
  logic [WORD_W-1:0] m_chan;
  logic [WORD_W-1:0] m_rem;

  function automatic void frame_restart();
    m_phase = m_chan_en ? PH_CHANNEL : PH_LENGTH;
    m_hidx  = 0;
    m_asm   = '0;
  endfunction

  function automatic void deframer_reset();
    m_chan_en = 1'b0;
    m_max     = MAX_LENGTH_RST;
    m_chan    = '0;
    m_rem     = '0;
    frame_restart();
  endfunction

  function automatic void apply_register_write(input logic [CFG_IDX_W-1:0] idx,
                                               input logic [WORD_W-1:0] val);
    case (idx)
      CFG_CHANNEL_ENABLE: begin
        // Only a real mode change drops a partial frame; halted stays halted.
        if (val[0] != m_chan_en) begin
          m_chan_en = val[0];
          if (m_phase != PH_HALTED) begin
            m_rem = '0;
            frame_restart();
          end
        end
      end
      CFG_MAX_LENGTH: m_max = val;
      default: ;
    endcase
  endfunction

  // One accepted byte in, zero or one predicted result out.
  function automatic void deframe_byte(input logic [7:0] b);
    result_t r;
    bit      emit;
    r    = '0;
    emit = 1'b0;
    case (m_phase)
      PH_CHANNEL, PH_LENGTH: begin
        // Header words wider than 32 bits keep only their low bytes.
        m_asm = (m_asm << 8) | WORD_W'(b);
        m_hidx++;
        if (m_hidx == HEADER_WORD_BYTES) begin
          m_hidx = 0;
          if (m_phase == PH_CHANNEL) begin
            m_chan  = m_asm;
            m_asm   = '0;
            m_phase = PH_LENGTH;
          end else begin
            m_rem = m_asm;
            m_asm = '0;
            if (m_rem > m_max) begin
              m_phase = PH_HALTED;
              emit    = 1'b1;
              r.kind  = KIND_ERROR;
              r.last  = 1'b1;
            end else if (m_rem == '0) begin
              emit   = 1'b1;
              r.kind = KIND_EMPTY;
              r.last = 1'b1;
              frame_restart();
            end else begin
              m_phase = PH_PAYLOAD;
            end
          end
        end
      end
      PH_PAYLOAD: begin
        m_rem--;
        emit   = 1'b1;
        r.kind = KIND_BYTE;
        r.data = b;
        r.last = (m_rem == '0);
        if (m_rem == '0) frame_restart();
      end
      default: ;  // halted: byte dropped
    endcase
    if (emit) begin
      r.channel = m_chan_en ? m_chan : '0;
      pending_results.push_back(r);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Input driver: bursts of random length with random gaps. The predictor
  // runs on each accepted byte, using the values seen before the edge.
  // --------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) deframe_byte(in_byte_i);
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          in_valid_i <= 1'b0;
          gap_left--;
        end else if (tx_bytes.size() > 0) begin
          in_byte_i  <= tx_bytes.pop_front();
          in_valid_i <= 1'b1;
          if (burst_left <= 1) begin
            // Now and then a long gapless stretch, else short bursts.
            if ($urandom_range(0, 3) == 0) begin
              burst_left = $urandom_range(100, 300);
              gap_left   = 0;
            end else begin
              burst_left = $urandom_range(1, 16);
              gap_left   = $urandom_range(0, 6);
            end
          end else begin
            burst_left--;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output side stall pattern. Windows of random length pick a ready
  // pattern; twice the receiver holds off for a long stretch while plenty
  // of bytes are queued, so the internal queue fills and in_ready_o drops.
  // --------------------------------------------------------------------------
  int hold_left  = 0;
  int holds_done = 0;
  int win_left   = 0;
  int win_mode   = 0;
  int stall_tick = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left--;
    end else if (holds_done < 2 && res_cnt >= (holds_done == 0 ? 200 : 900) &&
                 tx_bytes.size() > 40) begin
      out_ready_i <= 1'b0;
      hold_left = HOLD_CYCLES;
      holds_done++;
    end else begin
      if (win_left == 0) begin
        win_mode = $urandom_range(0, 3);
        win_left = $urandom_range(16, 128);
      end else begin
        win_left--;
      end
      stall_tick++;
      case (win_mode)
        0:       out_ready_i <= 1'b1;
        1:       out_ready_i <= 1'($urandom_range(0, 1));
        2:       out_ready_i <= ($urandom_range(0, 3) == 0);
        default: out_ready_i <= (stall_tick % 3 != 0);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Output monitor: every output transaction against the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      res_cnt++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result kind=%0d data=%02h channel=%08h last=%0b",
                 $time, kind_o, data_o, channel_o, last_o);
        fail_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (kind_o !== want.kind) begin
          $display("%0t: kind expected %0d actual %0d", $time, want.kind, kind_o);
          fail_cnt++;
        end
        if (data_o !== want.data) begin
          $display("%0t: data expected %02h actual %02h", $time, want.data, data_o);
          fail_cnt++;
        end
        if (channel_o !== want.channel) begin
          $display("%0t: channel expected %08h actual %08h",
                   $time, want.channel, channel_o);
          fail_cnt++;
        end
        if (last_o !== want.last) begin
          $display("%0t: last expected %0b actual %0b", $time, want.last, last_o);
          fail_cnt++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Big-endian header word, HEADER_WORD_BYTES long.
  function automatic void push_word(input logic [63:0] w);
    for (int i = HEADER_WORD_BYTES - 1; i >= 0; i--) tx_bytes.push_back(w[8*i +: 8]);
  endfunction

  // Whole frame in the mode the stimulus last set, random payload.
  function automatic void push_frame(input logic [WORD_W-1:0] chan,
                                     input logic [WORD_W-1:0] len);
    if (frame_mode) push_word(64'(chan));
    push_word(64'(len));
    for (int i = 0; i < int'(len); i++) tx_bytes.push_back(8'($urandom_range(0, 255)));
  endfunction

  // Sender pause: all bytes sent, all results back, pipeline drained.
  // Polled on the falling edge so the driver's updates have settled;
  // returns just after a rising edge.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (tx_bytes.size() != 0 || in_valid_i || pending_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Called right after a rising edge. Leaves cfg_valid_i high so writes can
  // run back to back; the caller lowers it after the last one.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    apply_register_write(idx, val);
  endtask

  // Random upper bits on the mode write check that only bit 0 counts.
  // With drop_partial set, the mode is flipped first so a cut-off frame is
  // thrown away whatever the new mode is.
  task automatic configure(input bit ce, input logic [WORD_W-1:0] ml, input bit drop_partial);
    logic [WORD_W-1:0] noise;
    noise = $urandom();
    if (drop_partial) cfg_write(CFG_CHANNEL_ENABLE, {noise[31:1], ~frame_mode});
    cfg_write(CFG_CHANNEL_ENABLE, {noise[31:1], ce});
    frame_mode = ce;
    cfg_write(CFG_MAX_LENGTH, ml);
    if ($urandom_range(0, 1)) cfg_write(CFG_SPARE_A, $urandom());
    else                      cfg_write(CFG_SPARE_B, $urandom());
    cfg_valid_i <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    bit                cut;
    int                fill;
    int                cap;
    int                len;
    int                mark;
    int                drop;
    bit                ce;
    logic [WORD_W-1:0] ml;

    deframer_reset();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- Directed: reset settings, no channel word ----
    push_word(64'd0);                        // empty message
    push_word(64'd2);                        // two bytes, all-zero and all-one
    tx_bytes.push_back(8'h00);
    tx_bytes.push_back(8'hFF);
    wait_idle();

    // Channel mode, length limit 3: a frame right at the limit, then an empty
    // one, then a channel word cut short and dropped by a mode change.
    configure(1'b1, 32'd3, 1'b0);
    push_word(64'hFFFF_FFFF);
    push_word(64'd3);
    tx_bytes.push_back(8'hA5);
    tx_bytes.push_back(8'h5A);
    tx_bytes.push_back(8'hFF);
    push_word(64'd0);
    push_word(64'd0);
    tx_bytes.push_back(8'hAB);
    tx_bytes.push_back(8'hCD);
    wait_idle();

    // Largest limit: the largest length is legal; two bytes of it, then
    // the mode change abandons the message.
    configure(1'b0, 32'hFFFF_FFFF, 1'b0);
    push_word(64'hFFFF_FFFF);
    tx_bytes.push_back(8'h3C);
    tx_bytes.push_back(8'hC3);
    wait_idle();
    cfg_write(CFG_CHANNEL_ENABLE, 32'd1);
    cfg_valid_i <= 1'b0;
    frame_mode = 1'b1;

    // Fresh frame after the abandon, stopped inside the length word; a write
    // of the same mode must leave that partial frame alone.
    push_word(64'h8000_0001);
    tx_bytes.push_back(8'h00);
    tx_bytes.push_back(8'h00);
    wait_idle();
    cfg_write(CFG_CHANNEL_ENABLE, 32'd1);
    cfg_valid_i <= 1'b0;
    tx_bytes.push_back(8'h00);
    tx_bytes.push_back(8'h01);
    tx_bytes.push_back(8'h7E);
    wait_idle();

    // ---- Random phases: register settings change between phases ----
    cut = 1'b0;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      ce = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 4))
        0:       ml = '0;
        1:       ml = $urandom_range(1, 8);
        2:       ml = 32'hFFFF_FFFF;
        3:       ml = MAX_LENGTH_RST;
        default: ml = $urandom() | 32'h100;
      endcase
      configure(ce, ml, cut);
      cap  = (ml < 16) ? int'(ml) : 16;
      fill = 0;
      while (fill < PHASE_BYTES) begin
        mark = tx_bytes.size();
        len  = ($urandom_range(0, 7) == 0) ? cap : $urandom_range(0, cap);
        push_frame($urandom(), len);
        fill += tx_bytes.size() - mark;
      end
      // Some phases end on a truncated frame.
      cut = ($urandom_range(0, 2) == 0);
      if (cut) begin
        mark = tx_bytes.size();
        push_frame($urandom(), $urandom_range(0, cap));
        drop = $urandom_range(1, tx_bytes.size() - mark - 1);
        repeat (drop) void'(tx_bytes.pop_back());
      end
      wait_idle();
    end

    // ---- Oversize length last: the block halts until reset ----
    // Length word split by a limit change; the new limit must apply to it.
    configure(1'b0, MAX_LENGTH_RST, cut);
    tx_bytes.push_back(8'h00);
    tx_bytes.push_back(8'h00);
    wait_idle();
    cfg_write(CFG_MAX_LENGTH, 32'd4);
    cfg_valid_i <= 1'b0;
    tx_bytes.push_back(8'h00);
    tx_bytes.push_back(8'h05);
    repeat (20) tx_bytes.push_back(8'($urandom_range(0, 255)));
    wait_idle();
    // Mode change while halted: still no results.
    cfg_write(CFG_CHANNEL_ENABLE, 32'd1);
    cfg_valid_i <= 1'b0;
    frame_mode = 1'b1;
    repeat (12) tx_bytes.push_back(8'($urandom_range(0, 255)));
    wait_idle();

    if (fail_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
